/* hdl/potential_field_velocity_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the potential field velocity block
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef POTENTIAL_FIELD_VELOCITY_ASSERT_SVH
`define POTENTIAL_FIELD_VELOCITY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge out of reset.
`define PFV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("potential_field_velocity: assertion failed");

// Check that a condition never occurs out of reset.
`define PFV_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("potential_field_velocity: forbidden condition");

`else

`define PFV_ASSERT(label, clk, rst_n, prop)
`define PFV_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* hdl/pfv_pkg.sv */
// ----------------------------------------------------------------------------
// pfv_pkg
// Types, widths and codes shared by the potential field velocity block.
// ----------------------------------------------------------------------------
package pfv_pkg;

    localparam int FRAC_BITS     = 10;
    localparam int GAIN_FRAC     = 8;
    localparam int MAX_OBSTACLES = 8;

    // Saturation width of one repulsion term.
    localparam int TERM_W    = 50;
    localparam int G_SHIFT   = 16;
    localparam int REP_SHIFT = 4 * FRAC_BITS - 16;

    // Shared long divider.
    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 61;
    localparam int DIV_SH_W  = 6;
    localparam int DIV_CNT_W = 7;
    localparam int DIV_Q_W   = TERM_W;

    // Shared square root.
    localparam int SQ_IN_W  = 62;
    localparam int SQ_OUT_W = SQ_IN_W / 2;

    // The larger normalized magnitude lies in [2^(NORM_TOP-1), 2^NORM_TOP).
    localparam int NORM_TOP = 30;

    localparam logic [15:0] ATT_RESET  = 16'd2560;
    localparam logic [15:0] REP_RESET  = 16'd2560;
    localparam logic [14:0] RAD_RESET  = 15'd3072;
    localparam logic [14:0] STEP_RESET = 15'd1024;

    localparam logic [1:0] REG_ATT  = 2'd0;
    localparam logic [1:0] REG_REP  = 2'd1;
    localparam logic [1:0] REG_RAD  = 2'd2;
    localparam logic [1:0] REG_STEP = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [2:0]         obstacle_index;
        logic signed [15:0] obstacle_x;
        logic signed [15:0] obstacle_y;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        logic [3:0]         obstacle_count;
    } pfv_in_t;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic               degenerate;
    } pfv_out_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } pfv_obs_t;

    typedef struct packed {
        logic wr;
        logic shift;
    } pfv_cell_ctrl_t;

endpackage

/* hdl/pfv_cell.sv */
// ----------------------------------------------------------------------------
// pfv_cell
// One obstacle slot of the ring; loads on write, takes its neighbor on shift.
// ----------------------------------------------------------------------------
module pfv_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pfv_pkg::pfv_cell_ctrl_t ctrl,
    input  pfv_pkg::pfv_obs_t       wr_data,
    input  pfv_pkg::pfv_obs_t       nbr,
    output pfv_pkg::pfv_obs_t       q
);

    pfv_pkg::pfv_obs_t entry_reg;
    pfv_pkg::pfv_obs_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr)
        begin
            entry_next = wr_data;
        end
        else if (ctrl.shift)
        begin
            entry_next = nbr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

/* hdl/pfv_sqrt.sv */
// ----------------------------------------------------------------------------
// pfv_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pfv_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pfv_pkg::SQ_IN_W-1:0]  din,
    output logic                         done,
    output logic [pfv_pkg::SQ_OUT_W-1:0] root
);

    localparam int IW    = pfv_pkg::SQ_IN_W;
    localparam int OW    = pfv_pkg::SQ_OUT_W;
    localparam int CNT_W = $clog2(OW + 1);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [IW-1:0]    val_reg,  val_next;
    logic [OW+1:0]    rem_reg,  rem_next;
    logic [OW-1:0]    root_reg, root_next;

    logic [OW+3:0] rem_sh;
    logic [OW+3:0] trial;
    logic [OW+3:0] diff;
    logic          ge;

    assign rem_sh = {rem_reg, val_reg[IW-1:IW-2]};
    assign trial  = (OW + 4)'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(OW);
            val_next  = din;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            val_next  = {val_reg[IW-3:0], 2'b00};
            rem_next  = ge ? diff[OW+1:0] : rem_sh[OW+1:0];
            root_next = {root_reg[OW-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hdl/pfv_div.sv */
// ----------------------------------------------------------------------------
// pfv_div
// Restoring divider for floor(num * 2^shift / den), saturating the quotient.
// ----------------------------------------------------------------------------
module pfv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pfv_pkg::DIV_NUM_W-1:0] num,
    input  logic [pfv_pkg::DIV_DEN_W-1:0] den,
    input  logic [pfv_pkg::DIV_SH_W-1:0]  shift,
    output logic                          done,
    output logic [pfv_pkg::DIV_Q_W-1:0]   quo
);

    localparam int NW = pfv_pkg::DIV_NUM_W;
    localparam int DW = pfv_pkg::DIV_DEN_W;
    localparam int QW = pfv_pkg::DIV_Q_W;
    localparam int CW = pfv_pkg::DIV_CNT_W;

    logic          run_reg,  run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [NW-1:0] num_reg,  num_next;
    logic [DW-1:0] den_reg,  den_next;
    logic [DW-1:0] rem_reg,  rem_next;
    logic [QW-1:0] q_reg,    q_next;
    logic          sat_reg,  sat_next;

    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(NW) + CW'(shift);
            num_next = num;
            den_next = den;
            rem_next = '0;
            q_next   = '0;
            sat_next = 1'b0;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            q_next   = {q_reg[QW-2:0], ge};
            // a one shifted out of the top means the quotient passed the cap
            sat_next = sat_reg | q_reg[QW-1];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quo  = sat_reg ? {QW{1'b1}} : q_reg;

endmodule

/* hdl/potential_field_velocity.sv */
// ----------------------------------------------------------------------------
// potential_field_velocity
// Two-dimensional potential field velocity: attraction to a goal plus
// repulsion from stored obstacles, normalized to a fixed step length.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A write
// transaction (op = write) stores one obstacle and returns nothing. A query
// transaction returns exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so sample it then. Obstacles sit in a ring of
// MAX_OBSTACLES cells that rotates one cell as each obstacle is finished. A
// query tests each obstacle against the influence radius; for each one inside
// it, it runs a square root, a gain division and two parallel force divisions,
// with setup around them. It then rotates the ring back to its home position,
// once per remaining slot, normalizes the summed force, takes its root and
// runs the final division. The serial square root and long dividers set the
// query time. Configuration is to be written over the APB port only while
// busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "potential_field_velocity_assert.svh"

module potential_field_velocity #(
    parameter int MAX_OBSTACLES = pfv_pkg::MAX_OBSTACLES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pfv_pkg::pfv_in_t  cmd,
    output logic              busy,
    output logic              done,
    output pfv_pkg::pfv_out_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(MAX_OBSTACLES + 1);
    localparam int SUM_W = pfv_pkg::TERM_W + $clog2(MAX_OBSTACLES + 1) + 1;
    localparam int RR_W  = 15 + pfv_pkg::GAIN_FRAC;
    localparam int NW    = pfv_pkg::DIV_NUM_W;
    localparam int DW    = pfv_pkg::DIV_DEN_W;
    localparam int NT    = pfv_pkg::NORM_TOP;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ATT    = 5'd1;
    localparam logic [4:0] S_NEXT   = 5'd2;
    localparam logic [4:0] S_DIST   = 5'd3;
    localparam logic [4:0] S_SQ     = 5'd4;
    localparam logic [4:0] S_TEST   = 5'd5;
    localparam logic [4:0] S_SQRT   = 5'd6;
    localparam logic [4:0] S_GMUL   = 5'd7;
    localparam logic [4:0] S_GSTART = 5'd8;
    localparam logic [4:0] S_GDIV   = 5'd9;
    localparam logic [4:0] S_PMUL   = 5'd10;
    localparam logic [4:0] S_PSTART = 5'd11;
    localparam logic [4:0] S_PDIV   = 5'd12;
    localparam logic [4:0] S_UNWIND = 5'd13;
    localparam logic [4:0] S_MAG    = 5'd14;
    localparam logic [4:0] S_NORM   = 5'd15;
    localparam logic [4:0] S_NSQ    = 5'd16;
    localparam logic [4:0] S_NADD   = 5'd17;
    localparam logic [4:0] S_NSQRT  = 5'd18;
    localparam logic [4:0] S_VMUL   = 5'd19;
    localparam logic [4:0] S_VSTART = 5'd20;
    localparam logic [4:0] S_VDIV   = 5'd21;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] att_gain_reg;
    logic [15:0] rep_gain_reg;
    logic [14:0] radius_reg;
    logic [14:0] step_reg;
    logic        cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_gain_reg <= pfv_pkg::ATT_RESET;
            rep_gain_reg <= pfv_pkg::REP_RESET;
            radius_reg   <= pfv_pkg::RAD_RESET;
            step_reg     <= pfv_pkg::STEP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                pfv_pkg::REG_ATT:  att_gain_reg <= pwdata[15:0];
                pfv_pkg::REG_REP:  rep_gain_reg <= pwdata[15:0];
                pfv_pkg::REG_RAD:  radius_reg   <= pwdata[14:0];
                pfv_pkg::REG_STEP: step_reg     <= pwdata[14:0];
                default:           att_gain_reg <= att_gain_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pfv_pkg::REG_ATT:  prdata = 32'(att_gain_reg);
            pfv_pkg::REG_REP:  prdata = 32'(rep_gain_reg);
            pfv_pkg::REG_RAD:  prdata = 32'(radius_reg);
            pfv_pkg::REG_STEP: prdata = 32'(step_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Obstacle ring: cell i holds entry i whenever the block is idle; each
    // rotation moves the next entry into cell 0, the head.
    // ------------------------------------------------------------------
    logic [4:0]               state_reg, state_next;
    logic                     rot;
    logic                     wr_take;
    pfv_pkg::pfv_obs_t        cell_q    [MAX_OBSTACLES];
    pfv_pkg::pfv_cell_ctrl_t  cell_ctrl [MAX_OBSTACLES];
    pfv_pkg::pfv_obs_t        wr_entry;
    pfv_pkg::pfv_obs_t        head;

    assign busy     = state_reg != S_IDLE;
    assign wr_take  = start & ~busy & (cmd.op == pfv_pkg::OP_WRITE);
    assign wr_entry = '{x: cmd.obstacle_x, y: cmd.obstacle_y};
    assign head     = cell_q[0];

    for (genvar i = 0; i < MAX_OBSTACLES; i++)
    begin : g_ring
        assign cell_ctrl[i].wr    = wr_take & (32'(cmd.obstacle_index) == i);
        assign cell_ctrl[i].shift = rot;

        pfv_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl[i]),
            .wr_data (wr_entry),
            .nbr     (cell_q[(i + 1) % MAX_OBSTACLES]),
            .q       (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Shared arithmetic units
    // ------------------------------------------------------------------
    logic                          sq_start;
    logic [pfv_pkg::SQ_IN_W-1:0]   sq_din;
    logic                          sq_done;
    logic [pfv_pkg::SQ_OUT_W-1:0]  sq_root;

    logic                          div_a_start, div_b_start;
    logic [NW-1:0]                 div_a_num,   div_b_num;
    logic [DW-1:0]                 div_den;
    logic [pfv_pkg::DIV_SH_W-1:0]  div_shift;
    logic                          div_a_done,  div_b_done;
    logic [pfv_pkg::DIV_Q_W-1:0]   div_a_quo,   div_b_quo;

    pfv_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .din   (sq_din),
        .done  (sq_done),
        .root  (sq_root)
    );

    pfv_div u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_a_start),
        .num   (div_a_num),
        .den   (div_den),
        .shift (div_shift),
        .done  (div_a_done),
        .quo   (div_a_quo)
    );

    pfv_div u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_b_start),
        .num   (div_b_num),
        .den   (div_den),
        .shift (div_shift),
        .done  (div_b_done),
        .quo   (div_b_quo)
    );

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]          idx_reg,  idx_next;
    logic [IDX_W-1:0]          cnt_reg,  cnt_next;
    logic                      degen_reg, degen_next;
    logic                      done_reg, done_next;
    pfv_pkg::pfv_out_t         res_reg,  res_next;
    logic signed [15:0]        cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [16:0]        dgx_reg,  dgx_next,  dgy_reg,  dgy_next;
    logic signed [SUM_W-1:0]   fx_reg,   fx_next,   fy_reg,   fy_next;
    logic [29:0]               rsq_reg,  rsq_next;
    logic [15:0]               ax_reg,   ax_next,   ay_reg,   ay_next;
    logic                      sx_reg,   sx_next,   sy_reg,   sy_next;
    logic [32:0]               d2_reg,   d2_next;
    logic [RR_W-1:0]           dh_reg,   dh_next;
    logic [NW-1:0]             gnum_reg, gnum_next;
    logic [31:0]               g_reg,    g_next;
    logic [NW-1:0]             pnx_reg,  pnx_next,  pny_reg,  pny_next;
    logic [DW-1:0]             dd_reg,   dd_next;
    logic [SUM_W-1:0]          mx_reg,   mx_next,   my_reg,   my_next;
    logic [2*NT-1:0]           sqx_reg,  sqx_next,  sqy_reg,  sqy_next;
    logic [pfv_pkg::SQ_OUT_W-1:0] nrm_reg, nrm_next;
    logic [NW-1:0]             vnx_reg,  vnx_next,  vny_reg,  vny_next;

    // Products, each registered in the state that uses it.
    logic [RR_W-1:0]           rr;
    logic signed [33:0]        att_px,  att_py;
    logic signed [16:0]        tx,      ty;
    logic [31:0]               sqa,     sqb;
    logic [RR_W-1:0]           gdiff;
    logic [RR_W+15:0]          gprod;
    logic [47:0]               gpx,     gpy;
    logic [59:0]               d2sq;
    logic [2*NT-1:0]           msqx,    msqy;
    logic [NT+14:0]            vpx,     vpy;
    logic [SUM_W-1:0]          orv;
    logic [14:0]               vmx,     vmy;
    logic [4:0]                cnt_in;

    assign rr     = RR_W'(radius_reg) << pfv_pkg::GAIN_FRAC;
    assign att_px = $signed({1'b0, att_gain_reg}) * dgx_reg;
    assign att_py = $signed({1'b0, att_gain_reg}) * dgy_reg;
    assign tx     = {cur_x_reg[15], cur_x_reg} - {head.x[15], head.x};
    assign ty     = {cur_y_reg[15], cur_y_reg} - {head.y[15], head.y};
    assign sqa    = ax_reg * ax_reg;
    assign sqb    = ay_reg * ay_reg;
    assign gdiff  = rr - dh_reg;
    assign gprod  = rep_gain_reg * gdiff;
    assign gpx    = g_reg * ax_reg;
    assign gpy    = g_reg * ay_reg;
    assign d2sq   = d2_reg[29:0] * d2_reg[29:0];
    assign msqx   = mx_reg[NT-1:0] * mx_reg[NT-1:0];
    assign msqy   = my_reg[NT-1:0] * my_reg[NT-1:0];
    assign vpx    = mx_reg[NT-1:0] * step_reg;
    assign vpy    = my_reg[NT-1:0] * step_reg;
    assign orv    = mx_reg | my_reg;
    assign cnt_in = {1'b0, cmd.obstacle_count};

    // Saturate the rounded quotients to the largest positive velocity.
    assign vmx = (|div_a_quo[pfv_pkg::DIV_Q_W-1:15]) ? 15'h7FFF : div_a_quo[14:0];
    assign vmy = (|div_b_quo[pfv_pkg::DIV_Q_W-1:15]) ? 15'h7FFF : div_b_quo[14:0];

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        degen_next  = degen_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        dgx_next    = dgx_reg;
        dgy_next    = dgy_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        rsq_next    = rsq_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        d2_next     = d2_reg;
        dh_next     = dh_reg;
        gnum_next   = gnum_reg;
        g_next      = g_reg;
        pnx_next    = pnx_reg;
        pny_next    = pny_reg;
        dd_next     = dd_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        sqx_next    = sqx_reg;
        sqy_next    = sqy_reg;
        nrm_next    = nrm_reg;
        vnx_next    = vnx_reg;
        vny_next    = vny_reg;
        rot         = 1'b0;
        sq_start    = 1'b0;
        sq_din      = '0;
        div_a_start = 1'b0;
        div_b_start = 1'b0;
        div_a_num   = '0;
        div_b_num   = '0;
        div_den     = '0;
        div_shift   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start && cmd.op == pfv_pkg::OP_QUERY)
                begin
                    cur_x_next = cmd.cur_x;
                    cur_y_next = cmd.cur_y;
                    dgx_next   = {cmd.goal_x[15], cmd.goal_x} - {cmd.cur_x[15], cmd.cur_x};
                    dgy_next   = {cmd.goal_y[15], cmd.goal_y} - {cmd.cur_y[15], cmd.cur_y};
                    // clamp the count to the ring size
                    if (32'(cnt_in) > 32'(MAX_OBSTACLES))
                    begin
                        cnt_next = IDX_W'(MAX_OBSTACLES);
                    end
                    else
                    begin
                        cnt_next = IDX_W'(cnt_in);
                    end
                    degen_next = 1'b0;
                    state_next = S_ATT;
                end
            end

            S_ATT:
            begin
                fx_next    = SUM_W'(att_px);
                fy_next    = SUM_W'(att_py);
                rsq_next   = radius_reg * radius_reg;
                idx_next   = '0;
                state_next = S_NEXT;
            end

            S_NEXT:
            begin
                state_next = (idx_reg == cnt_reg) ? S_UNWIND : S_DIST;
            end

            S_DIST:
            begin
                ax_next    = tx[16] ? 16'(-tx) : tx[15:0];
                ay_next    = ty[16] ? 16'(-ty) : ty[15:0];
                sx_next    = tx[16];
                sy_next    = ty[16];
                state_next = S_SQ;
            end

            S_SQ:
            begin
                d2_next    = {1'b0, sqa} + {1'b0, sqb};
                state_next = S_TEST;
            end

            S_TEST:
            begin
                if (d2_reg == '0)
                begin
                    // coincident obstacle: stop summing, force a zero result
                    degen_next = 1'b1;
                    state_next = S_UNWIND;
                end
                else if (d2_reg > {3'b000, rsq_reg})
                begin
                    rot        = 1'b1;
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_NEXT;
                end
                else
                begin
                    sq_start   = 1'b1;
                    sq_din     = pfv_pkg::SQ_IN_W'({d2_reg, 16'h0000});
                    state_next = S_SQRT;
                end
            end

            S_SQRT:
            begin
                if (sq_done)
                begin
                    dh_next    = sq_root[RR_W-1:0];
                    state_next = S_GMUL;
                end
            end

            S_GMUL:
            begin
                gnum_next  = NW'(gprod);
                state_next = S_GSTART;
            end

            S_GSTART:
            begin
                div_a_start = 1'b1;
                div_a_num   = gnum_reg;
                div_den     = DW'(rr);
                div_shift   = pfv_pkg::DIV_SH_W'(pfv_pkg::G_SHIFT);
                state_next  = S_GDIV;
            end

            S_GDIV:
            begin
                if (div_a_done)
                begin
                    g_next     = div_a_quo[31:0];
                    state_next = S_PMUL;
                end
            end

            S_PMUL:
            begin
                pnx_next   = NW'(gpx);
                pny_next   = NW'(gpy);
                dd_next    = DW'(d2sq);
                state_next = S_PSTART;
            end

            S_PSTART:
            begin
                div_a_start = 1'b1;
                div_b_start = 1'b1;
                div_a_num   = pnx_reg;
                div_b_num   = pny_reg;
                div_den     = dd_reg;
                div_shift   = pfv_pkg::DIV_SH_W'(pfv_pkg::REP_SHIFT);
                state_next  = S_PDIV;
            end

            S_PDIV:
            begin
                if (div_a_done)
                begin
                    // repulsion points from the obstacle toward the current point
                    fx_next    = sx_reg ? fx_reg - SUM_W'(div_a_quo)
                                        : fx_reg + SUM_W'(div_a_quo);
                    fy_next    = sy_reg ? fy_reg - SUM_W'(div_b_quo)
                                        : fy_reg + SUM_W'(div_b_quo);
                    rot        = 1'b1;
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_NEXT;
                end
            end

            S_UNWIND:
            begin
                // advance the ring back to its home alignment
                if (idx_reg == IDX_W'(MAX_OBSTACLES))
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    rot      = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_MAG:
            begin
                idx_next = '0;
                mx_next  = fx_reg[SUM_W-1] ? SUM_W'(-fx_reg) : SUM_W'(fx_reg);
                my_next  = fy_reg[SUM_W-1] ? SUM_W'(-fy_reg) : SUM_W'(fy_reg);
                if (degen_reg || (fx_reg == '0 && fy_reg == '0))
                begin
                    res_next   = '{vel_x: 16'sd0, vel_y: 16'sd0, degenerate: 1'b1};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end

            S_NORM:
            begin
                // shift both magnitudes until the larger one has its top bit
                // just below NORM_TOP
                if (|orv[SUM_W-1:NT])
                begin
                    mx_next = mx_reg >> 1;
                    my_next = my_reg >> 1;
                end
                else if (!orv[NT-1])
                begin
                    mx_next = mx_reg << 1;
                    my_next = my_reg << 1;
                end
                else
                begin
                    state_next = S_NSQ;
                end
            end

            S_NSQ:
            begin
                sqx_next   = msqx;
                sqy_next   = msqy;
                state_next = S_NADD;
            end

            S_NADD:
            begin
                sq_start   = 1'b1;
                sq_din     = pfv_pkg::SQ_IN_W'({1'b0, sqx_reg} + {1'b0, sqy_reg});
                state_next = S_NSQRT;
            end

            S_NSQRT:
            begin
                if (sq_done)
                begin
                    nrm_next   = sq_root;
                    state_next = S_VMUL;
                end
            end

            S_VMUL:
            begin
                // round half away from zero: (2*m*step + n) / (2*n)
                vnx_next   = NW'({vpx, 1'b0}) + NW'(nrm_reg);
                vny_next   = NW'({vpy, 1'b0}) + NW'(nrm_reg);
                state_next = S_VSTART;
            end

            S_VSTART:
            begin
                div_a_start = 1'b1;
                div_b_start = 1'b1;
                div_a_num   = vnx_reg;
                div_b_num   = vny_reg;
                div_den     = DW'({nrm_reg, 1'b0});
                div_shift   = '0;
                state_next  = S_VDIV;
            end

            S_VDIV:
            begin
                if (div_a_done)
                begin
                    res_next.vel_x      = fx_reg[SUM_W-1] ? 16'(-{1'b0, vmx}) : {1'b0, vmx};
                    res_next.vel_y      = fy_reg[SUM_W-1] ? 16'(-{1'b0, vmy}) : {1'b0, vmy};
                    res_next.degenerate = 1'b0;
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            degen_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            degen_reg <= degen_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        dgx_reg   <= dgx_next;
        dgy_reg   <= dgy_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        rsq_reg   <= rsq_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        d2_reg    <= d2_next;
        dh_reg    <= dh_next;
        gnum_reg  <= gnum_next;
        g_reg     <= g_next;
        pnx_reg   <= pnx_next;
        pny_reg   <= pny_next;
        dd_reg    <= dd_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        nrm_reg   <= nrm_next;
        vnx_reg   <= vnx_next;
        vny_reg   <= vny_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PFV_ASSERT(a_done_after_query, clk, rst_n, done |-> $past(busy))
    `PFV_ASSERT(a_degen_zero, clk, rst_n, (done && result.degenerate) |-> (result.vel_x == 16'sd0 && result.vel_y == 16'sd0))
    `PFV_ASSERT(a_div_lockstep, clk, rst_n, div_b_done |-> div_a_done)
    `PFV_NEVER(a_ring_home, clk, rst_n, !busy && idx_reg != '0)

endmodule
